// ===== hdl/vmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vmt_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;
  localparam int COORD_W   = 32;
  localparam int SUM_W     = 66;
  localparam int QUO_W     = 33;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 4'd7;

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_DIR   = 2'd1,
    CMD_PROJ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
    logic               div_zero;
  } out_t;

  typedef struct packed {
    logic               translate;
    logic               proj;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } item_t;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_t;

endpackage
`default_nettype wire

// ===== hdl/vmt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vmt_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire vmt_pkg::in_t  in_data_i,
  input  wire logic          take_i,
  output logic               item_valid_o,
  output vmt_pkg::item_t     item_o
);
  import vmt_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;
  item_t      dec;

  always_comb begin
    dec           = '0;
    dec.x         = in_data_i.in_x;
    dec.y         = in_data_i.in_y;
    dec.z         = in_data_i.in_z;
    dec.translate = 1'b1;
    dec.proj      = 1'b0;
    unique case (in_data_i.cmd)
      CMD_POINT: begin
        dec.translate = 1'b1;
      end
      CMD_DIR: begin
        dec.translate = 1'b0;
      end
      CMD_PROJ: begin
        dec.proj = 1'b1;
      end
      default: begin
        dec.translate = 1'b1;
      end
    endcase
  end

  assign full_o       = (cnt_q == 2'd2);
  assign wr_en        = push_i && !full_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign rd_en        = take_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vmt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vmt_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic [vmt_pkg::SUM_W-FRAC_BITS-1:0]    num_i,
  input  wire logic [vmt_pkg::SUM_W-FRAC_BITS-1:0]    den_i,
  output logic      [vmt_pkg::QUO_W-1:0]              q_o,
  output logic                                        ovf_o
);
  import vmt_pkg::*;

  localparam int MW = SUM_W - FRAC_BITS;
  localparam int K  = COORD_W - FRAC_BITS;

  logic [MW-1:0]    rem_q [QUO_W+1];
  logic [MW-1:0]    den_q [QUO_W+1];
  logic [QUO_W-1:0] d_q   [QUO_W+1];
  logic [QUO_W-1:0] q_q   [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic [MW-1:0]    rem0;
  logic             ovf0;

  assign rem0 = num_i >> K;
  assign ovf0 = (rem0 >= den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf0 ? '0 : rem0;
      den_q[0] <= den_i;
      d_q[0]   <= {num_i[K-1:0], {(FRAC_BITS+1){1'b0}}};
      q_q[0]   <= '0;
      ovf_q[0] <= ovf0;
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_step
    logic [MW:0] trial, diff;
    logic        ge;
    assign trial = {rem_q[i-1], d_q[i-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[i-1]};
    assign ge    = (trial >= {1'b0, den_q[i-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[MW-1:0] : trial[MW-1:0];
        den_q[i] <= den_q[i-1];
        d_q[i]   <= {d_q[i-1][QUO_W-2:0], 1'b0};
        q_q[i]   <= {q_q[i-1][QUO_W-2:0], ge};
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign q_o   = q_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule
`default_nettype wire

// ===== hdl/vmt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vmt_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire vmt_pkg::cfg_t   cfg_i,
  input  wire logic            item_valid_i,
  input  wire vmt_pkg::item_t  item_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output vmt_pkg::out_t        res_o
);
  import vmt_pkg::*;

  localparam int RW    = SUM_W - FRAC_BITS;
  localparam int DEPTH = QUO_W + 1;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [2:0][31:0] cl;
    logic             sat;
    logic             proj;
    logic             wz;
    logic [2:0]       neg;
  } sb_t;

  logic signed [31:0] m  [4][4];
  logic signed [31:0] xv [3];

  logic               v1_q, v2_q, v3_q;
  logic signed [63:0] p_q  [3][4];
  logic signed [31:0] t_q  [4];
  logic               proj1_q, proj2_q;
  logic signed [RW-1:0] r2_q [4];

  logic [RW-1:0]      mag3_q [3];
  logic [RW-1:0]      wmag3_q;
  sb_t                sb3_q;

  sb_t                sb_q  [DEPTH];
  logic               vld_q [DEPTH];
  logic [QUO_W-1:0]   q     [3];
  logic               ovf   [3];

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m[r][c] = cfg_i[2*r + c/2][32*(c%2) +: 32];
    end
  end

  assign xv[0]  = item_i.x;
  assign xv[1]  = item_i.y;
  assign xv[2]  = item_i.z;
  assign take_o = en_i && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= item_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_s12
    logic signed [SUM_W-1:0] sum;
    for (genvar r = 0; r < 3; r++) begin : g_mul
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q[r][c] <= xv[r] * m[r][c];
        end
      end
    end
    assign sum = SUM_W'(p_q[0][c]) + SUM_W'(p_q[1][c]) + SUM_W'(p_q[2][c])
               + (SUM_W'(t_q[c]) <<< FRAC_BITS) + RND;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[c]  <= item_i.translate ? m[3][c] : 32'sd0;
        r2_q[c] <= RW'(sum >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      proj1_q <= item_i.proj;
      proj2_q <= proj1_q;
    end
  end

  logic [2:0]  sat3;
  logic [31:0] cl3 [3];
  logic [RW-1:0] mag3 [3];
  logic        wneg;

  assign wneg = r2_q[3][RW-1];

  for (genvar j = 0; j < 3; j++) begin : g_s3
    logic hi_ok;
    assign hi_ok   = (r2_q[j][RW-1:31] == '0) || (r2_q[j][RW-1:31] == '1);
    assign sat3[j] = !hi_ok;
    assign cl3[j]  = hi_ok ? r2_q[j][31:0]
                   : (r2_q[j][RW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    assign mag3[j] = r2_q[j][RW-1] ? RW'(-r2_q[j]) : RW'(r2_q[j]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        mag3_q[j]     <= mag3[j];
        sb3_q.cl[j]   <= cl3[j];
        sb3_q.neg[j]  <= r2_q[j][RW-1] ^ wneg;
      end
      wmag3_q    <= wneg ? RW'(-r2_q[3]) : RW'(r2_q[3]);
      sb3_q.sat  <= |sat3;
      sb3_q.proj <= proj2_q;
      sb3_q.wz   <= (r2_q[3] == '0);
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    vmt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (mag3_q[j]),
      .den_i (wmag3_q),
      .q_o   (q[j]),
      .ovf_o (ovf[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= v3_q;
      for (int i = 1; i < DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb3_q;
      for (int i = 1; i < DEPTH; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  sb_t         sbo;
  logic [31:0] val [3];
  logic [2:0]  sat;

  assign sbo = sb_q[DEPTH-1];

  for (genvar j = 0; j < 3; j++) begin : g_fin
    logic [QUO_W:0]   inc;
    logic [QUO_W-1:0] qr;
    logic             big_pos, big_neg;
    assign inc     = {1'b0, q[j]} + (QUO_W+1)'(1);
    assign qr      = inc[QUO_W:1];
    assign big_pos = ovf[j] || (qr > QUO_W'(32'h7fff_ffff));
    assign big_neg = ovf[j] || (qr > QUO_W'(32'h8000_0000));
    always_comb begin
      if (!sbo.proj) begin
        val[j] = sbo.cl[j];
        sat[j] = 1'b0;
      end else if (sbo.wz) begin
        val[j] = '0;
        sat[j] = 1'b0;
      end else if (!sbo.neg[j]) begin
        val[j] = big_pos ? 32'h7fff_ffff : qr[31:0];
        sat[j] = big_pos;
      end else begin
        val[j] = big_neg ? 32'h8000_0000 : 32'(-qr);
        sat[j] = big_neg;
      end
    end
  end

  assign res_valid_o     = vld_q[DEPTH-1];
  assign res_o.out_x     = val[0];
  assign res_o.out_y     = val[1];
  assign res_o.out_z     = val[2];
  assign res_o.saturated = (!sbo.proj && sbo.sat) || (|sat);
  assign res_o.div_zero  = sbo.proj && sbo.wz;

endmodule
`default_nettype wire

// ===== hdl/vertex_matrix_transform_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput is one vertex per cycle in every mode while the output queue is not
// full or is being popped; the three divide lanes are fully pipelined, one quotient
// bit per stage, and set most of the latency.
// Reset clears both queues and the pipeline valid bits and loads the identity matrix.
module vertex_matrix_transform_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire vmt_pkg::in_t                      in_data_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output vmt_pkg::out_t                          out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [vmt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [vmt_pkg::CFG_W-1:0]         cfg_data_i
);
  import vmt_pkg::*;

  cfg_t       cfg_q;
  logic       item_valid, take, res_valid, en;
  item_t      item;
  out_t       res;
  out_t       omem_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       opush, opop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q               <= '0;
      cfg_q[REG_ROW0_C01] <= CFG_W'(65536);
      cfg_q[REG_ROW1_C01] <= CFG_W'(64'h0001_0000_0000_0000);
      cfg_q[REG_ROW2_C23] <= CFG_W'(65536);
      cfg_q[REG_ROW3_C23] <= CFG_W'(64'h0001_0000_0000_0000);
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  vmt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  vmt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign empty      = (ocnt_q == 2'd0);
  assign en         = (ocnt_q != 2'd2) || pop;
  assign opush      = en && res_valid;
  assign opop       = pop && !empty;
  assign out_data_o = omem_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (opush) begin
      omem_q[owr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) begin
        owr_q <= !owr_q;
      end
      if (opop) begin
        ord_q <= !ord_q;
      end
      if (opush && !opop) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (opop && !opush) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire
